// File: rtl/core/ugbs_pkg.sv
// ============================================================================
// ugbs_pkg - shared definitions for the gradient block sum core
// Sizes, register indexes and pipeline record types of the block summer.
// ============================================================================
package ugbs_pkg;

    // Sizing
    localparam int unsigned MAX_GRAD_WIDTH = 1024;
    localparam int unsigned MAX_SCALE      = 8;
    localparam int unsigned SAMPLE_BITS    = 16;

    // Fixed register widths
    localparam int unsigned SCALE_BITS = 4;
    localparam int unsigned WIDTH_BITS = 11;
    localparam int unsigned CFG_BITS   = 11;
    localparam int unsigned CFG_IDX_BITS = 1;

    // Derived widths
    localparam int unsigned SUM_BITS       = SAMPLE_BITS + 2 * $clog2(MAX_SCALE);
    localparam int unsigned COL_BITS       = $clog2(MAX_GRAD_WIDTH);
    localparam int unsigned SC_CNT_BITS    = (MAX_SCALE > 2) ? $clog2(MAX_SCALE) : 1;
    localparam int unsigned IN_TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int unsigned OUT_TDATA_BITS = ((SUM_BITS + 7) / 8) * 8;

    // Output buffer
    localparam int unsigned OBUF_DEPTH = 3;
    localparam int unsigned OBUF_BITS  = 2;

    // Reset values of the registers
    localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(2);
    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(64);

    // Register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SCALE      = 1'b0,
        REG_GRAD_WIDTH = 1'b1
    } t_reg_idx;

    typedef logic signed [SUM_BITS-1:0] t_sum;

    // Block close record handed from the accept stage to the accumulate stage
    typedef struct packed {
        t_sum                psum;
        logic [COL_BITS-1:0] addr;
        logic                use_acc;
        logic                fwd;
        logic                emit;
        logic                row_end;
    } t_s1;

    typedef struct packed {
        t_sum block_sum;
        logic row_end;
    } t_result;

    function automatic t_sum sext_sample(input logic [SAMPLE_BITS-1:0] x);
        return {{(SUM_BITS - SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
    endfunction

endpackage

// File: rtl/core/upsample_gradient_block_sum.sv
// ============================================================================
// upsample_gradient_block_sum - scale-by-scale block summer for gradients
// Sums non-overlapping square blocks of a raster gradient plane in Q8.8.
// ============================================================================
// Usage
// The slave stream carries one gradient sample per beat in raster order:
// tdata holds the signed sample, tuser[0] marks the first sample of a plane
// and clears every position counter and the horizontal partial sum. The
// master stream carries one block sum per finished block: tdata holds the
// signed sum, tlast marks the last block sum of an output row.
// The block takes one beat per cycle while the output buffer has room. The
// edge that accepts the beat closing a block also registers the accumulator
// memory read; the next edge adds and moves the sum into the output buffer,
// from which it leaves on the master side.
// The column accumulators live in a synchronous memory with one read port
// and one write port, one entry per block column; when a block reads the
// entry that the block before it writes at the same edge, the value being
// written is forwarded to it.
// A three-entry output buffer decouples the two sides; tready on the slave
// side depends only on its fill and on the result in flight, so a stalled
// receiver stops intake after at most the buffered results, and nothing is
// dropped. Reset is synchronous and active low; it clears the counters, the
// partial sum, the buffer and the pipeline and restores scale to 2 and the
// row width to 64. The memory needs no clearing: the first row of every
// block row writes its entry before any row reads it. The user must write
// the registers via the cfg port only while idle; the block does not enforce it.
// ============================================================================
module upsample_gradient_block_sum (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // Slave stream
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  logic [ugbs_pkg::IN_TDATA_BITS-1:0]      i_s_axis_tdata,  // grad_value
    input  logic [0:0]                              i_s_axis_tuser,  // plane_start
    // Master stream
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    output logic [ugbs_pkg::OUT_TDATA_BITS-1:0]     o_m_axis_tdata,  // block_sum
    output logic                                    o_m_axis_tlast,  // row_end
    // Configuration
    input  logic                                    i_cfg_we,
    input  logic [ugbs_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [ugbs_pkg::CFG_BITS-1:0]           i_cfg_data
);

    localparam int unsigned CB = ugbs_pkg::COL_BITS;
    localparam int unsigned SB = ugbs_pkg::SC_CNT_BITS;

    // Configuration registers
    logic [ugbs_pkg::SCALE_BITS-1:0] r_scale;
    logic [ugbs_pkg::WIDTH_BITS-1:0] r_grad_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale      <= ugbs_pkg::SCALE_RESET;
            r_grad_width <= ugbs_pkg::WIDTH_RESET;
        end else if (i_cfg_we) begin
            case (ugbs_pkg::t_reg_idx'(i_cfg_index))
                ugbs_pkg::REG_SCALE:      r_scale <= i_cfg_data[ugbs_pkg::SCALE_BITS-1:0];
                ugbs_pkg::REG_GRAD_WIDTH: r_grad_width <= i_cfg_data[ugbs_pkg::WIDTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Out-of-range register values are clamped into the legal range.
    logic [31:0] eff_scale;
    logic [31:0] eff_width;

    always_comb begin
        if (r_scale == '0)                  eff_scale = 32'd1;
        else if (32'(r_scale) > ugbs_pkg::MAX_SCALE) eff_scale = ugbs_pkg::MAX_SCALE;
        else                                eff_scale = 32'(r_scale);
        if (r_grad_width == '0)             eff_width = 32'd1;
        else if (32'(r_grad_width) > ugbs_pkg::MAX_GRAD_WIDTH)
            eff_width = ugbs_pkg::MAX_GRAD_WIDTH;
        else                                eff_width = 32'(r_grad_width);
    end

    // Position state
    logic [CB-1:0]          r_col,  n_col;
    logic [CB-1:0]          r_bcol, n_bcol;
    logic [SB-1:0]          r_pib,  n_pib;
    logic [SB-1:0]          r_rib,  n_rib;
    ugbs_pkg::t_sum         r_psum, n_psum;

    // Pipeline, memory and output buffer state
    ugbs_pkg::t_s1          r_s1, n_s1;
    logic                   r_s1_valid;
    ugbs_pkg::t_sum         r_fwd_data;
    ugbs_pkg::t_sum         r_rd_q;
    ugbs_pkg::t_sum         mem [ugbs_pkg::MAX_GRAD_WIDTH];

    ugbs_pkg::t_result      r_obuf [ugbs_pkg::OBUF_DEPTH];
    logic [ugbs_pkg::OBUF_BITS-1:0] r_wptr, r_rptr, r_ocnt;

    // Accept stage: counters with the plane start applied first
    logic                   in_acc;
    logic                   plane;
    logic [CB-1:0]          cp, bc;
    logic [SB-1:0]          pib, rib;
    ugbs_pkg::t_sum         ps, psum_add;
    logic                   row_done, block_done, rib_last;

    // Accumulate stage
    ugbs_pkg::t_sum         s1_acc;
    logic                   mem_we;
    logic                   s1_push;
    logic                   out_pop;

    assign plane    = i_s_axis_tuser[0];
    assign cp       = plane ? '0 : r_col;
    assign bc       = plane ? '0 : r_bcol;
    assign pib      = plane ? '0 : r_pib;
    assign rib      = plane ? '0 : r_rib;
    assign ps       = plane ? '0 : r_psum;
    assign psum_add = ps + ugbs_pkg::sext_sample(i_s_axis_tdata[ugbs_pkg::SAMPLE_BITS-1:0]);

    assign row_done   = 32'(cp) >= eff_width - 32'd1;
    assign block_done = row_done || (32'(pib) >= eff_scale - 32'd1);
    assign rib_last   = 32'(rib) >= eff_scale - 32'd1;

    assign s1_acc  = r_s1.psum + (r_s1.use_acc ? (r_s1.fwd ? r_fwd_data : r_rd_q) : '0);
    assign mem_we  = r_s1_valid && !r_s1.emit;
    assign s1_push = r_s1_valid && r_s1.emit;
    assign out_pop = o_m_axis_tvalid && i_m_axis_tready;

    // Room for the result in flight plus one more keeps the buffer from overflowing.
    assign o_s_axis_tready = (32'(r_ocnt) + 32'(s1_push)) < ugbs_pkg::OBUF_DEPTH;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_psum = block_done ? '0 : psum_add;
        n_pib  = block_done ? '0 : pib + SB'(1);
        n_bcol = bc;
        if (block_done) begin
            n_bcol = (32'(bc) == ugbs_pkg::MAX_GRAD_WIDTH - 1) ? '0 : bc + CB'(1);
        end
        n_col = cp + CB'(1);
        n_rib = rib;
        if (row_done) begin
            n_col  = '0;
            n_bcol = '0;
            n_pib  = '0;
            n_rib  = rib_last ? '0 : rib + SB'(1);
        end

        n_s1.psum    = psum_add;
        n_s1.addr    = bc;
        n_s1.use_acc = rib != '0;
        n_s1.fwd     = mem_we && (r_s1.addr == bc);
        n_s1.emit    = rib_last;
        n_s1.row_end = row_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_bcol     <= '0;
            r_pib      <= '0;
            r_rib      <= '0;
            r_psum     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc && block_done;
            if (in_acc) begin
                r_col  <= n_col;
                r_bcol <= n_bcol;
                r_pib  <= n_pib;
                r_rib  <= n_rib;
                r_psum <= n_psum;
            end
        end
    end

    // Payload of the accumulate stage; the write of this cycle is captured
    // for a read that targets the same entry.
    always_ff @(posedge i_clk) begin
        if (in_acc && block_done) begin
            r_s1       <= n_s1;
            r_fwd_data <= s1_acc;
        end
    end

    // Column accumulator memory: one read at accept, one write in the following cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_s1.addr] <= s1_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && block_done) begin
            r_rd_q <= mem[bc];
        end
    end

    // Output buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_ocnt <= '0;
        end else begin
            if (s1_push) begin
                r_wptr <= (32'(r_wptr) == ugbs_pkg::OBUF_DEPTH - 1) ? '0 : r_wptr + 2'd1;
            end
            if (out_pop) begin
                r_rptr <= (32'(r_rptr) == ugbs_pkg::OBUF_DEPTH - 1) ? '0 : r_rptr + 2'd1;
            end
            r_ocnt <= r_ocnt + ugbs_pkg::OBUF_BITS'(s1_push) - ugbs_pkg::OBUF_BITS'(out_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_push) begin
            r_obuf[r_wptr].block_sum <= s1_acc;
            r_obuf[r_wptr].row_end   <= r_s1.row_end;
        end
    end

    assign o_m_axis_tvalid = r_ocnt != '0;
    assign o_m_axis_tdata  = {{(ugbs_pkg::OUT_TDATA_BITS - ugbs_pkg::SUM_BITS){1'b0}},
                              r_obuf[r_rptr].block_sum};
    assign o_m_axis_tlast  = r_obuf[r_rptr].row_end;

    // Assertions
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_push |-> 32'(r_ocnt) < ugbs_pkg::OBUF_DEPTH)
        else $error("output buffer written while full");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ocnt) <= ugbs_pkg::OBUF_DEPTH)
        else $error("output buffer count out of range");

    a_fwd_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1.fwd |-> $past(mem_we))
        else $error("forwarding without a write in the previous cycle");

    a_s1_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> $past(in_acc))
        else $error("accumulate stage active without an accepted beat");

endmodule

// File: tb/sv/tb_upsample_gradient_block_sum.sv
// ============================================================================
// tb_upsample_gradient_block_sum - self-checking bench for the block summer
// Streams gradient planes through the slave port, predicts every block sum
// in the bench and compares each master beat with the oldest prediction.
// Register settings change between phases. Both stream sides idle at random.
// ============================================================================
module tb_upsample_gradient_block_sum;

    import ugbs_pkg::*;

    // Documented register values after reset.
    localparam int unsigned RESET_SCALE = 2;
    localparam int unsigned RESET_WIDTH = 64;

    // The block puts a block sum into its output buffer and writes its
    // memory in the cycle after accepting the closing beat. The bench then
    // waits SETTLE_CYCLES before registers are touched or the run ends.
    localparam int unsigned SETTLE_CYCLES = 8;

    // A correct run ends well within this limit.
    localparam int unsigned CYCLE_LIMIT = 500000;

    // Idling modes of the two stream sides.
    localparam int unsigned IDLE_NONE     = 0;
    localparam int unsigned IDLE_SENDER   = 1;
    localparam int unsigned IDLE_RECEIVER = 2;
    localparam int unsigned IDLE_BOTH     = 3;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'h8000;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'h7FFF;

    // One slave beat: a gradient sample and its plane start flag.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          start;
    } t_grad_beat;

    // One master beat: the block sum and its row end flag.
    typedef struct packed {
        t_sum block_sum;
        logic row_end;
    } t_sum_beat;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [IN_TDATA_BITS-1:0]   s_tdata  = '0;
    logic [0:0]                 s_tuser  = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0]  m_tdata;
    logic                       m_tlast;
    logic                       cfg_we   = 1'b0;
    t_reg_idx                   cfg_index = REG_SCALE;
    logic [CFG_BITS-1:0]        cfg_data = '0;

    // Beats waiting for the driver, and block sums the block still owes.
    t_grad_beat grad_q[$];
    t_sum_beat  sums_due[$];

    // Set at each rising edge when the slave beat on the bus was taken.
    logic grad_taken = 1'b0;
    t_grad_beat next_beat;

    int unsigned sender_idle_pct  = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;

    // Bench copy of the block state and its registers.
    t_sum        col_acc [MAX_GRAD_WIDTH];
    t_sum        row_psum;
    int unsigned col_pos;
    int unsigned pos_in_bcol;
    int unsigned row_in_blk;
    int unsigned blk_col;
    logic [SCALE_BITS-1:0] scale_reg;
    logic [WIDTH_BITS-1:0] width_reg;

    upsample_gradient_block_sum uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // grad_value
        .i_s_axis_tuser  (s_tuser),   // plane_start
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // block_sum, zero padded
        .o_m_axis_tlast  (m_tlast),   // row_end
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Block sum predictor. Takes one accepted sample and queues the block sum
    // it completes, if any. Out-of-range register values are clamped the way
    // the block does: zero acts as one, anything above the maximum as the
    // maximum. Counters compare with >=, so a counter left past a smaller
    // limit by a register change closes its block or row on the next sample.
    // ------------------------------------------------------------------------
    task automatic accumulate_sample(input logic signed [SAMPLE_BITS-1:0] value,
                                     input logic start);
        int unsigned s;
        int unsigned w;
        int unsigned bc;
        logic        row_done;
        logic        blk_done;
        t_sum        sample;
        t_sum        total;
        t_sum_beat   beat;
        s = (scale_reg == 0) ? 1 : ((scale_reg > MAX_SCALE) ? MAX_SCALE : scale_reg);
        w = (width_reg == 0) ? 1
            : ((width_reg > MAX_GRAD_WIDTH) ? MAX_GRAD_WIDTH : width_reg);

        // A plane start clears the position and the partial sum, but the
        // column accumulators keep their contents.
        if (start) begin
            col_pos     = 0;
            pos_in_bcol = 0;
            row_in_blk  = 0;
            blk_col     = 0;
            row_psum    = '0;
        end

        sample   = value;
        row_psum = row_psum + sample;

        // The last sample of a row always closes a block, so a row width that
        // is not a multiple of the scale leaves a narrow last block column.
        row_done = (col_pos >= w - 1);
        blk_done = row_done || (pos_in_bcol >= s - 1);

        if (blk_done) begin
            bc    = blk_col % MAX_GRAD_WIDTH;
            total = row_psum;
            // The first row of a block overwrites the accumulator unread.
            if (row_in_blk != 0)
                total = total + col_acc[bc];
            row_psum = '0;
            if (row_in_blk >= s - 1) begin
                beat.block_sum = total;
                beat.row_end   = row_done;
                sums_due.insert(sums_due.size(), beat);
            end else begin
                col_acc[bc] = total;
            end
            pos_in_bcol = 0;
            blk_col     = (bc + 1) % MAX_GRAD_WIDTH;
        end else begin
            pos_in_bcol++;
        end

        if (row_done) begin
            col_pos     = 0;
            blk_col     = 0;
            pos_in_bcol = 0;
            if (row_in_blk >= s - 1)
                row_in_blk = 0;
            else
                row_in_blk++;
        end else begin
            col_pos++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: samples both streams and the register port at the rising edge,
    // before the block updates anything, so the values seen are the ones the
    // block acts on at this edge.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : monitor_proc
        t_sum_beat want;
        t_sum      got_sum;
        if (!rst_n) begin
            row_psum    = '0;
            col_pos     = 0;
            pos_in_bcol = 0;
            row_in_blk  = 0;
            blk_col     = 0;
            scale_reg   = SCALE_BITS'(RESET_SCALE);
            width_reg   = WIDTH_BITS'(RESET_WIDTH);
            grad_taken  = 1'b0;
        end else begin
            // Master side: every beat must match the oldest owed block sum.
            if (m_tvalid && m_tready) begin
                got_sum = m_tdata[SUM_BITS-1:0];
                if (sums_due.size() == 0) begin
                    $display("%0t: block sum beat with none owed: sum %0d, tlast %0b",
                             $time, got_sum, m_tlast);
                    fail_count++;
                end else begin
                    want = sums_due.pop_front();
                    if (got_sum !== want.block_sum) begin
                        $display("%0t: block_sum mismatch: expected %0d, actual %0d",
                                 $time, want.block_sum, got_sum);
                        fail_count++;
                    end
                    if (m_tlast !== want.row_end) begin
                        $display("%0t: row_end mismatch: expected %0b, actual %0b",
                                 $time, want.row_end, m_tlast);
                        fail_count++;
                    end
                end
            end

            // Slave side: predict from every accepted sample beat.
            grad_taken = s_tvalid && s_tready;
            if (grad_taken)
                accumulate_sample(s_tdata[SAMPLE_BITS-1:0], s_tuser[0]);

            // Register writes take effect for the next sample.
            if (cfg_we) begin
                case (cfg_index)
                    REG_SCALE:      scale_reg = cfg_data[SCALE_BITS-1:0];
                    REG_GRAD_WIDTH: width_reg = cfg_data[WIDTH_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: moves the next queued sample onto the slave stream at the
    // falling edge once the previous one was taken, unless the sender idles
    // this cycle. The receiver ready is redrawn every falling edge.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || grad_taken) begin
            if (grad_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                next_beat = grad_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_beat.value;
                s_tuser  <= next_beat.start;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Sample values lean on the extremes so that every bit toggles often.
    function automatic logic [SAMPLE_BITS-1:0] draw_grad_value();
        case ($urandom_range(9))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       return '0;
            3:       return '1;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic queue_sample(input logic [SAMPLE_BITS-1:0] value, input logic start);
        t_grad_beat beat;
        beat.value = value;
        beat.start = start;
        grad_q.insert(grad_q.size(), beat);
    endtask

    // One plane of random content. It always opens with a plane start, so the
    // accumulators it reads were written earlier in the same plane; a rare
    // stray plane start in the middle restarts the plane.
    task automatic queue_random_plane(input int unsigned count, input int unsigned restart_odds);
        int unsigned k;
        for (k = 0; k < count; k++)
            queue_sample(draw_grad_value(),
                         (k == 0) || (restart_odds != 0 && $urandom_range(restart_odds - 1) == 0));
    endtask

    task automatic set_idling(input int unsigned mode);
        case (mode)
            IDLE_SENDER:   begin sender_idle_pct = 56; receiver_stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 56; end
            IDLE_BOTH:     begin sender_idle_pct = 16; receiver_stall_pct = 16; end
            default:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        endcase
    endtask

    // Holds the sender back until every queued sample is taken and every
    // block sum owed has come out, then lets the pipeline settle.
    task automatic wait_until_idle();
        while (grad_q.size() != 0 || s_tvalid || sums_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_reg_idx index, input logic [CFG_BITS-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Register settings of the random phases. They cover the clamped values
    // (scale 0 and 15, width 0), widths that are not a multiple of the scale
    // and the largest width. The scale-8 phases get more samples since a
    // block row needs many of them.
    int unsigned ph_scale [12] = '{2, 3, 1, 8, 0, 15, 4, 5, 7, 2, 6, 3};
    int unsigned ph_width [12] = '{64, 9, 0, 16, 5, 24, 12, 10, 21, 1024, 14, 1};
    int unsigned ph_items [12] = '{120, 80, 50, 180, 50, 180, 80, 80, 100, 50, 70, 40};

    initial begin : stimulus_proc
        int unsigned p;
        int unsigned k;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --------------------------------------------------------------------
        // Directed part
        // --------------------------------------------------------------------
        set_idling(IDLE_NONE);

        // 2x2 blocks over a four sample row: one block of the most negative
        // samples, one of the most positive ones.
        write_reg(REG_SCALE, CFG_BITS'(2));
        write_reg(REG_GRAD_WIDTH, CFG_BITS'(4));
        for (k = 0; k < 8; k++)
            queue_sample((k % 4 < 2) ? SAMPLE_MIN : SAMPLE_MAX, k == 0);
        wait_until_idle();

        // Row width three with scale two: the last block column is one sample
        // wide. A second plane start right after the first restarts the plane.
        write_reg(REG_GRAD_WIDTH, CFG_BITS'(3));
        queue_sample(draw_grad_value(), 1'b1);
        queue_sample(draw_grad_value(), 1'b1);
        for (k = 0; k < 5; k++)
            queue_sample(draw_grad_value(), 1'b0);
        wait_until_idle();

        // Width shrinks in the middle of a row: the column counter already
        // lies past the new last column, so the next sample closes the row.
        queue_sample(draw_grad_value(), 1'b1);
        queue_sample(draw_grad_value(), 1'b0);
        wait_until_idle();
        write_reg(REG_GRAD_WIDTH, CFG_BITS'(2));
        for (k = 0; k < 3; k++)
            queue_sample(draw_grad_value(), 1'b0);
        wait_until_idle();

        // Scale shrinks in the middle of a block row: the row counter lies
        // past the new last row, so the next row emits its sums.
        write_reg(REG_SCALE, CFG_BITS'(8));
        for (k = 0; k < 4; k++)
            queue_sample(draw_grad_value(), k == 0);
        wait_until_idle();
        write_reg(REG_SCALE, CFG_BITS'(2));
        for (k = 0; k < 2; k++)
            queue_sample(draw_grad_value(), 1'b0);
        wait_until_idle();

        // Largest block, filled with one extreme and then the other: the smallest
        // sum the output can carry and the largest one that the samples can make.
        set_idling(IDLE_BOTH);
        write_reg(REG_SCALE, CFG_BITS'(8));
        write_reg(REG_GRAD_WIDTH, CFG_BITS'(8));
        for (k = 0; k < 128; k++)
            queue_sample((k < 64) ? SAMPLE_MIN : SAMPLE_MAX, k == 0);
        wait_until_idle();

        // --------------------------------------------------------------------
        // Random phases. Each one rewrites both registers while the block is
        // idle; the drain before each write is also where the sender holds
        // back until every owed sum has come out.
        // --------------------------------------------------------------------
        for (p = 0; p < 12; p++) begin
            set_idling(p % 4);
            write_reg(REG_SCALE, CFG_BITS'(ph_scale[p]));
            write_reg(REG_GRAD_WIDTH, CFG_BITS'(ph_width[p]));
            queue_random_plane(ph_items[p], 200);
            wait_until_idle();
        end

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
